// ===== rtl/b64enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared job type, alphabet lookup and default sizing for the stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One encoded job: up to four characters produced by a single input byte.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            eom;
  } job_t;

  // Map a sextet to its character in the standard alphabet.
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== rtl/b64enc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder channel interfaces
// Valid/ready channels for message bytes in and encoded characters out.
// ----------------------------------------------------------------------------
interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_message;

  modport source (output valid, output out_char, output end_of_message, input ready);
  modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface

// ===== rtl/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Padded Base64 encoder: one message byte in, one to four characters out.
//
//   channel   dir   payload                     per transaction
//   in_ch     in    data_byte, final_byte       one message byte
//   out_ch    out   out_char, end_of_message    one character or '='
//
// A byte is taken whenever the job queue has room; its characters leave
// one per cycle from the serializer while out_ch.ready is high, so a
// byte costs one to four output characters (1.33 on average in a long message).
// The one-character-per-cycle output port sets the sustained rate.
// Reset clears group phase, leftover bits, queue and serializer.
// Output stalls fill the queue, then drop in_ch.ready.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  b64enc_in_if.sink    in_ch,
  b64enc_out_if.source out_ch
);
  import b64enc_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== rtl/b64enc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks group phase and leftover bits, and builds one
// character job per byte, including flush and padding on the final byte.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic               clk,
  input  logic               rst,
  b64enc_in_if.sink          in_ch,
  input  logic               queue_full,
  output logic               push,
  output b64enc_pkg::job_t   push_job
);
  import b64enc_pkg::*;

  logic [3:0] leftover_bits;
  logic [1:0] group_phase;
  logic [3:0] leftover_bits_next;
  logic [1:0] group_phase_next;
  logic [3:0] left_kept;
  logic [1:0] phase_kept;
  logic [7:0] b;
  job_t       job;

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;
  assign push_job    = job;
  assign b           = in_ch.data_byte;

  always_comb begin
    job.chars    = '0;
    job.last_idx = 2'd0;
    job.eom      = in_ch.final_byte;
    left_kept    = 4'd0;
    phase_kept   = 2'd0;

    unique case (group_phase)
      2'd1: begin
        job.chars[0] = sextet_to_ascii({leftover_bits[1:0], b[7:4]});
        left_kept    = b[3:0];
        phase_kept   = 2'd2;
      end
      2'd2: begin
        job.chars[0] = sextet_to_ascii({leftover_bits, b[7:6]});
        job.chars[1] = sextet_to_ascii(b[5:0]);
        job.last_idx = 2'd1;
        left_kept    = 4'd0;
        phase_kept   = 2'd0;
      end
      default: begin
        job.chars[0] = sextet_to_ascii(b[7:2]);
        left_kept    = {2'b00, b[1:0]};
        phase_kept   = 2'd1;
      end
    endcase

    leftover_bits_next = left_kept;
    group_phase_next   = phase_kept;

    if (in_ch.final_byte) begin
      if (phase_kept == 2'd1) begin
        job.chars[1] = sextet_to_ascii({left_kept[1:0], 4'b0000});
        job.chars[2] = PAD_CHAR;
        job.chars[3] = PAD_CHAR;
        job.last_idx = 2'd3;
      end else if (phase_kept == 2'd2) begin
        job.chars[1] = sextet_to_ascii({left_kept, 2'b00});
        job.chars[2] = PAD_CHAR;
        job.last_idx = 2'd2;
      end
      leftover_bits_next = 4'd0;
      group_phase_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits <= 4'd0;
      group_phase   <= 2'd0;
    end else if (push) begin
      leftover_bits <= leftover_bits_next;
      group_phase   <= group_phase_next;
    end
  end

endmodule

// ===== rtl/b64enc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short FIFO of character jobs between front end and serializer.
// ----------------------------------------------------------------------------
module b64enc_queue #(
  parameter int unsigned Depth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64enc_pkg::job_t   push_job,
  output logic               full,
  input  logic               pop,
  output b64enc_pkg::job_t   pop_job,
  output logic               empty
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && !empty) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      priority if ((push && !full) && !(pop && !empty)) begin
        count <= count + CntW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/b64enc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder serializer
// Holds one job and sends its characters one per transaction.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               queue_empty,
  input  b64enc_pkg::job_t   pop_job,
  output logic               pop,
  b64enc_out_if.source       out_ch
);
  import b64enc_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       sent;
  logic       job_done;

  assign sent     = out_ch.valid && out_ch.ready;
  assign job_done = sent && (idx == cur.last_idx);
  assign pop      = !queue_empty && (!busy || job_done);

  assign out_ch.valid          = busy;
  assign out_ch.out_char       = cur.chars[idx];
  assign out_ch.end_of_message = cur.eom && (idx == cur.last_idx);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      priority if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (job_done) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else if (sent) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
